/* src/positional_array_list_assert.svh */
// Assertion macros shared by the positional array list RTL.
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define PAL_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define PAL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/pal_pkg.sv */
// Shared types, codes and defaults for the positional array list.
`default_nettype none
package pal_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int ELEM_WIDTH_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LENGTH_W = 5;
    localparam int CAP_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_INSERT = 2'd0;
    localparam action_t ACT_DELETE = 2'd1;
    localparam action_t ACT_GET    = 2'd2;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_FULL   = 2'd1;
    localparam status_t ST_EMPTY  = 2'd2;
    localparam status_t ST_BADPOS = 2'd3;

    // Read address source; the index register follows every read address.
    typedef logic [1:0] rd_sel_t;
    localparam rd_sel_t RD_POS  = 2'd0;
    localparam rd_sel_t RD_TAIL = 2'd1;
    localparam rd_sel_t RD_UP   = 2'd2;
    localparam rd_sel_t RD_DOWN = 2'd3;

    // Write address and data source.
    typedef logic [1:0] wr_sel_t;
    localparam wr_sel_t WR_BELOW = 2'd0;
    localparam wr_sel_t WR_ABOVE = 2'd1;
    localparam wr_sel_t WR_POS   = 2'd2;

    typedef struct packed {
        logic    load_req;
        logic    cap_status;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    capture_res;
        logic    len_inc;
        logic    len_dec;
        logic    out_load;
    } pal_cmd_t;

    typedef struct packed {
        logic    req_ok;
        action_t act;
        logic    more_up;
        logic    more_down;
        logic    tail_move;
    } pal_stat_t;

endpackage
`default_nettype wire

/* src/positional_array_list.sv */
// Top level of the positional array list: stream ports, controller and datapath.
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tuser: action; tdata: position, value_in
//  m_axis    out        m_axis_tvalid/m_axis_tready  tuser: status; tdata: value_out, length,
//                                                    is_full, is_empty
//  cfg       in         cfg_valid/cfg_ready          cfg_data: capacity
//
//  One request at a time. Insert and delete shift the entries between the position and
//  the tail; the shift moves one entry per cycle through the store's single read and
//  write port. A new request is taken while the previous result beat still waits on
//  m_axis_tready; the result register holds it until taken.
//  Reset (aresetn low, synchronous) empties the list, sets capacity to 16, keeps the store.
`default_nettype none
`include "positional_array_list_assert.svh"
module positional_array_list #(
    parameter int DEPTH      = pal_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = pal_pkg::ELEM_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [4:0] position, [36:5] value_in, [39:37] zero
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] action

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] value_out, [36:32] length,
                                             // [37] is_full, [38] is_empty, [39] zero
    output logic [1:0]       m_axis_tuser,   // [1:0] status

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data        // capacity
);
    import pal_pkg::*;

    pal_cmd_t                    cmd;
    pal_stat_t                   stat;
    status_t                     res_status;
    logic signed [VALUE_W-1:0]   res_value;
    logic [LENGTH_W-1:0]         res_length;
    logic                        res_full;
    logic                        res_empty;

    // Capacity writes go straight into the capacity register; always ready.
    assign cfg_ready = 1'b1;

    pal_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pal_datapath #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .in_action   (s_axis_tuser),
        .in_position (s_axis_tdata[4:0]),
        .in_value    ($signed(s_axis_tdata[36:5])),
        .cmd         (cmd),
        .stat        (stat),
        .out_status  (res_status),
        .out_value   (res_value),
        .out_length  (res_length),
        .out_full    (res_full),
        .out_empty   (res_empty)
    );

    // Pack the result beat, lowest field first.
    assign m_axis_tdata = {1'b0, res_empty, res_full, res_length, $unsigned(res_value)};
    assign m_axis_tuser = res_status;

    // The block goes busy straight after taking a request.
    `PAL_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn,
        s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "request taken while previous one still in work")
    // The reported length never passes the store depth.
    `PAL_ASSERT_IMPLY(a_length_in_range, aclk, aresetn,
        m_axis_tvalid, m_axis_tdata[36:32] <= DEPTH,
        "reported length beyond store depth")
    // A full rejection leaves the list full.
    `PAL_ASSERT_IMPLY(a_full_flag, aclk, aresetn,
        m_axis_tvalid && (m_axis_tuser == ST_FULL), m_axis_tdata[37],
        "full status without full flag")
    // Any rejection carries a zero value.
    `PAL_ASSERT_IMPLY(a_reject_zero, aclk, aresetn,
        m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata[31:0] == 32'd0,
        "rejected request returned a value")

endmodule
`default_nettype wire

/* src/pal_datapath.sv */
// Datapath: request registers, entry store, length, capacity and result register.
`default_nettype none
module pal_datapath #(
    parameter int DEPTH      = pal_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = pal_pkg::ELEM_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    input  wire logic [pal_pkg::CAP_W-1:0]     cfg_data,
    input  wire pal_pkg::action_t              in_action,
    input  wire logic [pal_pkg::POS_W-1:0]     in_position,
    input  wire logic signed [pal_pkg::VALUE_W-1:0] in_value,
    input  wire pal_pkg::pal_cmd_t             cmd,
    output pal_pkg::pal_stat_t                 stat,
    output pal_pkg::status_t                   out_status,
    output logic signed [pal_pkg::VALUE_W-1:0] out_value,
    output logic [pal_pkg::LENGTH_W-1:0]       out_length,
    output logic                               out_full,
    output logic                               out_empty
);
    import pal_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int CW    = (LEN_W > POS_W) ? LEN_W : POS_W;

    logic [ELEM_WIDTH-1:0] store_mem [DEPTH];

    action_t               act_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [ELEM_WIDTH-1:0] val_reg;
    logic [AW-1:0]         idx_reg;
    logic [ELEM_WIDTH-1:0] rd_data_reg;
    logic [ELEM_WIDTH-1:0] res_reg;
    status_t               status_reg;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [CAP_W-1:0]      cap_reg;

    status_t               out_status_reg;
    logic [VALUE_W-1:0]    out_value_reg;
    logic [LENGTH_W-1:0]   out_length_reg;
    logic                  out_full_reg;
    logic                  out_empty_reg;

    logic [63:0]           val_wide;
    logic [63:0]           res_wide;
    logic [CW-1:0]         len_ext, pos_ext, cap_ext, cap_eff, depth_c, len_m1;
    logic                  is_full, is_empty;
    status_t               status_code;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic [ELEM_WIDTH-1:0] wr_data;

    assign val_wide = 64'($unsigned(in_value));
    assign res_wide = 64'(res_reg);

    assign len_ext = CW'(len_reg);
    assign pos_ext = CW'(pos_reg);
    assign cap_ext = CW'(cap_reg);
    assign depth_c = CW'(DEPTH);
    assign len_m1  = len_ext - CW'(1);
    assign cap_eff = (cap_ext == '0) ? CW'(1) : ((cap_ext > depth_c) ? depth_c : cap_ext);

    assign is_full  = (len_ext >= cap_eff);
    assign is_empty = (len_reg == '0);

    always_comb begin
        case (act_reg)
            ACT_INSERT: begin
                if (is_full)
                    status_code = ST_FULL;
                else if (pos_ext > len_ext)
                    status_code = ST_BADPOS;
                else
                    status_code = ST_OK;
            end
            ACT_DELETE, ACT_GET: begin
                if (is_empty)
                    status_code = ST_EMPTY;
                else if (pos_ext >= len_ext)
                    status_code = ST_BADPOS;
                else
                    status_code = ST_OK;
            end
            default: status_code = ST_BADPOS;
        endcase
    end

    assign stat.req_ok    = (status_code == ST_OK);
    assign stat.act       = act_reg;
    assign stat.more_up   = ((CW'(idx_reg) + CW'(1)) < len_ext);
    assign stat.more_down = (CW'(idx_reg) > pos_ext);
    assign stat.tail_move = (pos_ext < len_ext);

    always_comb begin
        unique case (cmd.rd_sel)
            RD_POS:  rd_addr = pos_ext[AW-1:0];
            RD_TAIL: rd_addr = len_m1[AW-1:0];
            RD_UP:   rd_addr = idx_reg + AW'(1);
            RD_DOWN: rd_addr = idx_reg - AW'(1);
            default: rd_addr = idx_reg;
        endcase
    end

    always_comb begin
        unique case (cmd.wr_sel)
            WR_BELOW: begin
                wr_addr = idx_reg - AW'(1);
                wr_data = rd_data_reg;
            end
            WR_ABOVE: begin
                wr_addr = idx_reg + AW'(1);
                wr_data = rd_data_reg;
            end
            WR_POS: begin
                wr_addr = pos_ext[AW-1:0];
                wr_data = val_reg;
            end
            default: begin
                wr_addr = idx_reg;
                wr_data = rd_data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en)
            store_mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= store_mem[rd_addr];
    end

    always_comb begin
        len_next = len_reg;
        if (cmd.len_inc)
            len_next = len_reg + LEN_W'(1);
        else if (cmd.len_dec)
            len_next = len_reg - LEN_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            cap_reg <= CAP_RESET;
        end else begin
            len_reg <= len_next;
            if (cfg_valid)
                cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            act_reg <= in_action;
            pos_reg <= in_position;
            val_reg <= val_wide[ELEM_WIDTH-1:0];
            res_reg <= '0;
        end else if (cmd.capture_res) begin
            res_reg <= rd_data_reg;
        end
        if (cmd.rd_en)
            idx_reg <= rd_addr;
        if (cmd.cap_status)
            status_reg <= status_code;
        if (cmd.out_load) begin
            out_status_reg <= status_reg;
            out_value_reg  <= res_wide[VALUE_W-1:0];
            out_length_reg <= LENGTH_W'(len_reg);
            out_full_reg   <= is_full;
            out_empty_reg  <= is_empty;
        end
    end

    assign out_status = out_status_reg;
    assign out_value  = $signed(out_value_reg);
    assign out_length = out_length_reg;
    assign out_full   = out_full_reg;
    assign out_empty  = out_empty_reg;

endmodule
`default_nettype wire

/* src/pal_ctrl.sv */
// Controller: sequences checks, entry shifts and result hand-off.
`default_nettype none
module pal_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire pal_pkg::pal_stat_t stat,
    output pal_pkg::pal_cmd_t       cmd
);
    import pal_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_HEAD     = 3'd2;
    localparam logic [2:0] S_DEL_MOVE = 3'd3;
    localparam logic [2:0] S_INS_MOVE = 3'd4;
    localparam logic [2:0] S_INS_PUT  = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_POS;
        cmd.wr_sel = WR_POS;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.cap_status = 1'b1;
                if (!stat.req_ok) begin
                    state_next = S_DONE;
                end else if (stat.act == ACT_INSERT) begin
                    if (stat.tail_move) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_TAIL;
                        state_next = S_INS_MOVE;
                    end else begin
                        state_next = S_INS_PUT;
                    end
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_POS;
                    state_next = S_HEAD;
                end
            end
            S_HEAD: begin
                cmd.capture_res = 1'b1;
                if (stat.act == ACT_DELETE) begin
                    if (stat.more_up) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_UP;
                        state_next = S_DEL_MOVE;
                    end else begin
                        cmd.len_dec = 1'b1;
                        state_next  = S_DONE;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DEL_MOVE: begin
                // drop each later entry one place down
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_BELOW;
                if (stat.more_up) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_UP;
                end else begin
                    cmd.len_dec = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_INS_MOVE: begin
                // lift entries one place up, from the tail towards the position
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_ABOVE;
                if (stat.more_down) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_DOWN;
                end else begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_POS;
                cmd.len_inc = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (!valid_reg || out_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.out_load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;

endmodule
`default_nettype wire

/* tb/sv/positional_array_list_tb.sv */
// Self-checking testbench for the positional array list over its stream and configuration ports.
module positional_array_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pal_pkg::*;

    // Action code the block does not define; it must come back as bad position.
    localparam action_t ACT_UNUSED  = 2'd3;
    localparam int      LIST_CELLS  = DEPTH_DEF;
    // Longest accept-to-accept time of one request, plus margin, in cycles.
    localparam int      SETTLE_CYC  = DEPTH_DEF + 8;
    localparam int      RANDOM_ITEMS = 1000;
    localparam int      SEGMENTS    = 10;

    typedef struct {
        status_t              status;
        logic [VALUE_W-1:0]   value;
        logic [LENGTH_W-1:0]  length;
        logic                 full;
        logic                 empty;
    } list_result_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [39:0]        s_axis_tdata  = '0;   // [4:0] position, [36:5] value_in, [39:37] zero
    logic [1:0]         s_axis_tuser  = '0;   // [1:0] action
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [39:0]        m_axis_tdata;         // [31:0] value_out, [36:32] length,
                                              // [37] is_full, [38] is_empty, [39] zero
    logic [1:0]         m_axis_tuser;         // [1:0] status
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [CAP_W-1:0]   cfg_data      = '0;

    // Shadow of the list, kept in step with every accepted request.
    logic [VALUE_W-1:0] list_cells [LIST_CELLS];
    int unsigned        list_len  = 0;
    logic [CAP_W-1:0]   cap_reg   = CAP_RESET;

    list_result_t       pending_results[$];
    int                 mismatch_count = 0;

    // Idling switches for the sender and the receiver.
    bit                 tx_idle_en = 1'b1;
    bit                 rx_idle_en = 1'b1;

    positional_array_list uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Capacity as the block uses it: zero counts as one, anything past the row as full depth.
    function automatic int unsigned usable_capacity();
        if (cap_reg == 0)
            return 1;
        if (cap_reg > LIST_CELLS)
            return LIST_CELLS;
        return 32'(cap_reg);
    endfunction

    // Apply one accepted request to the shadow list and queue the result it must give.
    function automatic void list_apply(action_t act, logic [POS_W-1:0] pos,
                                       logic [VALUE_W-1:0] val);
        list_result_t res;
        int unsigned  cap;
        cap        = usable_capacity();
        res.status = ST_OK;
        res.value  = '0;
        case (act)
            ACT_INSERT: begin
                if (list_len >= cap) begin
                    res.status = ST_FULL;
                end else if (pos > list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (int i = list_len; i > pos; i--)
                        list_cells[i] = list_cells[i-1];
                    list_cells[pos] = val;
                    list_len++;
                end
            end
            ACT_DELETE: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos >= list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    res.value = list_cells[pos];
                    for (int i = pos; i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i+1];
                    list_len--;
                end
            end
            ACT_GET: begin
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else if (pos >= list_len)
                    res.status = ST_BADPOS;
                else
                    res.value = list_cells[pos];
            end
            default: begin
                res.status = ST_BADPOS;
            end
        endcase
        res.length = list_len[LENGTH_W-1:0];
        res.full   = (list_len >= cap);
        res.empty  = (list_len == 0);
        pending_results.push_back(res);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, want %h at %0t ns", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Send one request beat. Valid is left high after acceptance so that back-to-back
    // beats never lower and raise it within one step; a gap lowers it first.
    task automatic send_request(action_t act, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] val);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, val, pos};
        s_axis_tuser  <= act;
        do @(posedge aclk); while (!s_axis_tready);
        list_apply(act, pos, val);
    endtask

    // Hold the sender until every pending result has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Write the capacity register with the block idle.
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        drain_results();
        repeat (SETTLE_CYC) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge aclk); while (!cfg_ready);
        cap_reg    = cap;
        cfg_valid <= 1'b0;
    endtask

    // Requests on a list that has never held anything.
    task automatic test_empty_list();
        send_request(ACT_GET,    5'd0, 32'h0000_0000);
        send_request(ACT_DELETE, 5'd0, 32'h0000_0000);
        send_request(ACT_INSERT, 5'd1, 32'h1234_5678);
        send_request(ACT_UNUSED, 5'd0, 32'hFFFF_FFFF);
    endtask

    // Extreme values, shifting inserts and deletes, and position checks.
    task automatic test_insert_delete_get();
        send_request(ACT_INSERT, 5'd0,  32'h8000_0000);
        send_request(ACT_INSERT, 5'd1,  32'h7FFF_FFFF);
        send_request(ACT_INSERT, 5'd0,  32'hFFFF_FFFF);
        send_request(ACT_INSERT, 5'd31, 32'h0000_0001);
        send_request(ACT_GET,    5'd2,  32'h0000_0000);
        send_request(ACT_GET,    5'd3,  32'h0000_0000);
        send_request(ACT_DELETE, 5'd31, 32'h0000_0000);
        send_request(ACT_DELETE, 5'd1,  32'h0000_0000);
        send_request(ACT_GET,    5'd0,  32'h0000_0000);
        send_request(ACT_GET,    5'd1,  32'h0000_0000);
    endtask

    // Capacity zero acts as one and is already below the length; an oversized value
    // acts as full depth.
    task automatic test_capacity_limits();
        write_capacity(5'd0);
        send_request(ACT_INSERT, 5'd0, 32'hA5A5_A5A5);
        send_request(ACT_DELETE, 5'd0, 32'h0000_0000);
        send_request(ACT_INSERT, 5'd0, 32'h5A5A_5A5A);
        send_request(ACT_DELETE, 5'd0, 32'h0000_0000);
        send_request(ACT_INSERT, 5'd0, 32'h0000_0000);
        write_capacity(5'd31);
        send_request(ACT_INSERT, 5'd1, 32'hDEAD_BEEF);
        send_request(ACT_GET,    5'd5, 32'h0000_0000);
        write_capacity(CAP_RESET);
    endtask

    // Mostly well-formed requests with random content, some out-of-range positions
    // and unused action codes. Each segment sets its own capacity, idling mode and
    // leaning towards inserts or deletes so the list runs between empty and full.
    task automatic test_random_traffic();
        logic [CAP_W-1:0]   seg_caps [SEGMENTS];
        int                 per_seg;
        int                 ins_pct;
        int                 r;
        action_t            act;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
        seg_caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd5, 5'd2, 5'd17, 5'd8, 5'd12, 5'd16};
        per_seg  = RANDOM_ITEMS / SEGMENTS;
        for (int s = 0; s < SEGMENTS; s++) begin
            write_capacity((s == 8) ? CAP_W'($urandom_range(0, 31)) : seg_caps[s]);
            tx_idle_en = (s % 4 == 0) || (s % 4 == 2);
            rx_idle_en = (s % 4 == 0) || (s % 4 == 3);
            ins_pct    = (s % 2 == 0) ? 70 : 25;
            for (int n = 0; n < per_seg; n++) begin
                // Hold the sender once mid-segment until the pipeline is empty.
                if (s == 4 && n == per_seg / 2)
                    drain_results();
                r = $urandom_range(0, 99);
                if (r < 4)
                    act = ACT_UNUSED;
                else if (r < 4 + ins_pct)
                    act = ACT_INSERT;
                else
                    act = $urandom_range(0, 1) ? ACT_DELETE : ACT_GET;
                if ($urandom_range(0, 99) < 12)
                    pos = POS_W'($urandom_range(0, 31));
                else if (act == ACT_INSERT)
                    pos = POS_W'($urandom_range(0, list_len));
                else
                    pos = (list_len > 0) ? POS_W'($urandom_range(0, list_len - 1)) : '0;
                case ($urandom_range(0, 19))
                    0:       val = 32'h8000_0000;
                    1:       val = 32'h7FFF_FFFF;
                    2:       val = 32'hFFFF_FFFF;
                    3:       val = 32'h0000_0000;
                    default: val = $urandom();
                endcase
                send_request(act, pos, val);
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Receiver: draw a stall before each beat, then hold ready until a beat is taken.
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = rx_idle_en ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    // Compare every result beat with the oldest pending result, field by field.
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", m_axis_tdata[31:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                if (m_axis_tdata[31:0] !== want.value)
                    report_mismatch("value_out", m_axis_tdata[31:0], want.value);
                if (m_axis_tdata[36:32] !== want.length)
                    report_mismatch("length", 32'(m_axis_tdata[36:32]), 32'(want.length));
                if (m_axis_tdata[37] !== want.full)
                    report_mismatch("is_full", 32'(m_axis_tdata[37]), 32'(want.full));
                if (m_axis_tdata[38] !== want.empty)
                    report_mismatch("is_empty", 32'(m_axis_tdata[38]), 32'(want.empty));
            end
        end
    end

    // Abandon a hung run.
    initial begin
        #(5_000_000);
        $display("FAIL positional_array_list");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_list();
        test_insert_delete_get();
        test_capacity_limits();
        test_random_traffic();

        // Let the last results out, then allow the block to settle.
        drain_results();
        repeat (SETTLE_CYC) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("results still pending", 32'(pending_results.size()), '0);

        if (mismatch_count == 0) begin
            $display("PASS positional_array_list");
        end else begin
            $display("FAIL positional_array_list");
        end
        $finish;
    end

endmodule
